// ----- rtl/thick_line_rasterizer_core_defines.svh -----
// Assertion macros for the thick line rasterizer core.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef THICK_LINE_RASTERIZER_CORE_DEFINES_SVH
`define THICK_LINE_RASTERIZER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define TLR_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("tlr: same-cycle check failed");
`define TLR_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("tlr: next-cycle check failed");
`else
`define TLR_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define TLR_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

// ----- rtl/tlr_pkg.sv -----
// Shared constants and types for the thick line rasterizer.
// No dependencies; used by the channel interfaces, the setup logic and the core.
`default_nettype none

package tlr_pkg;

  localparam int COORD_BITS_DEFAULT = 10;
  localparam int COLOR_BITS         = 4;

  // input operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // index of the last of the three pixels in a column
  localparam logic [1:0] LAST_BEAT = 2'd2;

  typedef struct packed {
    logic axis_swapped;
    logic minor_down;
  } tlr_flags_t;

endpackage

`default_nettype wire

// ----- rtl/tlr_chan_if.sv -----
// Valid/ready channel interfaces for the rasterizer input and pixel output.
// Depends on tlr_pkg for default widths.
`default_nettype none

interface tlr_in_if #(
  parameter int COORD_BITS = tlr_pkg::COORD_BITS_DEFAULT
);
  import tlr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [COORD_BITS-1:0] x_start;
  logic [COORD_BITS-1:0] y_start;
  logic [COORD_BITS-1:0] x_end;
  logic [COORD_BITS-1:0] y_end;
  logic [COLOR_BITS-1:0] pen_color;

  modport source (output valid, op, x_start, y_start, x_end, y_end, pen_color,
                  input ready);
  modport sink   (input valid, op, x_start, y_start, x_end, y_end, pen_color,
                  output ready);
endinterface

interface tlr_out_if #(
  parameter int COORD_BITS = tlr_pkg::COORD_BITS_DEFAULT
);
  import tlr_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS+1:0] pixel_x;
  logic signed [COORD_BITS+1:0] pixel_y;
  logic [COLOR_BITS-1:0]        pixel_color;
  logic                         line_done;

  modport source (output valid, pixel_x, pixel_y, pixel_color, line_done,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_color, line_done,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/tlr_setup.sv -----
// Line setup: picks the major axis, orders the endpoints and primes the
// error term and increments. Purely combinational; depends on tlr_pkg.
`default_nettype none

module tlr_setup #(
  parameter int COORD_BITS = tlr_pkg::COORD_BITS_DEFAULT
) (
  input  logic [COORD_BITS-1:0] x_start,
  input  logic [COORD_BITS-1:0] y_start,
  input  logic [COORD_BITS-1:0] x_end,
  input  logic [COORD_BITS-1:0] y_end,
  output logic [COORD_BITS-1:0] major_pos,
  output logic [COORD_BITS-1:0] major_end,
  output logic [COORD_BITS-1:0] minor_pos,
  output tlr_pkg::tlr_flags_t   flags,
  output logic [COORD_BITS+1:0] inc_straight,
  output logic [COORD_BITS+2:0] inc_diagonal,
  output logic [COORD_BITS+2:0] error_init
);
  import tlr_pkg::*;

  localparam int N = COORD_BITS;

  logic [N:0]   dx, dy, dx_neg, dy_neg;
  logic [N-1:0] adx, ady;
  logic         swapped, reorder, down;
  logic [N-1:0] ma, na, mb, nb;
  logic [N-1:0] ma_f, na_f, mb_f, nb_f;
  logic [N-1:0] dmaj, dmin;

  always_comb begin
    dx     = {1'b0, x_end} - {1'b0, x_start};
    dy     = {1'b0, y_end} - {1'b0, y_start};
    dx_neg = '0 - dx;
    dy_neg = '0 - dy;
    adx    = dx[N] ? dx_neg[N-1:0] : dx[N-1:0];
    ady    = dy[N] ? dy_neg[N-1:0] : dy[N-1:0];
    // ties stay on the x axis
    swapped = ady > adx;
    if (swapped) begin
      ma = y_start; na = x_start; mb = y_end; nb = x_end;
    end else begin
      ma = x_start; na = y_start; mb = x_end; nb = y_end;
    end
    // walk toward the larger major coordinate
    reorder = ma > mb;
    ma_f = reorder ? mb : ma;
    mb_f = reorder ? ma : mb;
    na_f = reorder ? nb : na;
    nb_f = reorder ? na : nb;
    down = na_f > nb_f;
    dmaj = mb_f - ma_f;
    dmin = down ? (na_f - nb_f) : (nb_f - na_f);

    major_pos          = ma_f;
    major_end          = mb_f;
    minor_pos          = na_f;
    flags.axis_swapped = swapped;
    flags.minor_down   = down;
    inc_straight       = {1'b0, dmin, 1'b0};
    inc_diagonal       = {2'b00, dmin, 1'b0} - {2'b00, dmaj, 1'b0};
    error_init         = {2'b00, dmin, 1'b0} - {3'b000, dmaj};
  end

endmodule

`default_nettype wire

// ----- rtl/thick_line_rasterizer_core.sv -----
// Thick line rasterizer core: a tick yields its three pixels starting the cycle
// after transfer, one per cycle while the output is ready; the next item
// transfers with the third pixel, paced by the single pixel output port.
// A load emits nothing, nor does a tick while no line is active.
// Reset (rst_n low, synchronous) clears the line state; no line is active.
`default_nettype none
`include "thick_line_rasterizer_core_defines.svh"

module thick_line_rasterizer_core #(
  parameter int COORD_BITS = tlr_pkg::COORD_BITS_DEFAULT
) (
  input  logic   clk,
  input  logic   rst_n,
  tlr_in_if.sink    in_chan,
  tlr_out_if.source out_chan
);
  import tlr_pkg::*;

  localparam int N     = COORD_BITS;
  localparam int ERR_W = COORD_BITS + 3;
  localparam int INC_W = COORD_BITS + 2;
  localparam int OUT_W = COORD_BITS + 2;

  // line state
  logic                  active_r;
  tlr_flags_t            flags_r;
  logic [N-1:0]          major_pos_r, major_end_r, minor_pos_r;
  logic [ERR_W-1:0]      error_r;
  logic [INC_W-1:0]      inc_straight_r;
  logic [ERR_W-1:0]      inc_diagonal_r;
  logic [COLOR_BITS-1:0] color_r;

  // column buffer feeding the pixel port
  logic                  col_valid_r;
  logic [1:0]            beat_r;
  logic                  col_swapped_r, col_last_r;
  logic [N-1:0]          col_major_r, col_minor_r;
  logic [COLOR_BITS-1:0] col_color_r;

  // setup results
  logic [N-1:0]          su_major_pos, su_major_end, su_minor_pos;
  tlr_flags_t            su_flags;
  logic [INC_W-1:0]      su_inc_straight;
  logic [ERR_W-1:0]      su_inc_diagonal, su_error_init;

  logic                  in_xfer, out_xfer, last_beat_xfer;
  logic                  load_go, tick_go, last_col;
  logic [ERR_W-1:0]      error_nxt;
  logic [N-1:0]          minor_nxt;
  logic [OUT_W-1:0]      minor_out, major_out;

  tlr_setup #(.COORD_BITS(COORD_BITS)) u_setup (
    .x_start      (in_chan.x_start),
    .y_start      (in_chan.y_start),
    .x_end        (in_chan.x_end),
    .y_end        (in_chan.y_end),
    .major_pos    (su_major_pos),
    .major_end    (su_major_end),
    .minor_pos    (su_minor_pos),
    .flags        (su_flags),
    .inc_straight (su_inc_straight),
    .inc_diagonal (su_inc_diagonal),
    .error_init   (su_error_init)
  );

  assign out_xfer       = out_chan.valid && out_chan.ready;
  assign last_beat_xfer = out_xfer && (beat_r == LAST_BEAT);
  assign in_chan.ready  = !col_valid_r || last_beat_xfer;
  assign in_xfer        = in_chan.valid && in_chan.ready;
  assign load_go        = in_xfer && (in_chan.op == OP_LOAD);
  assign tick_go        = in_xfer && (in_chan.op == OP_TICK) && active_r;
  assign last_col       = major_pos_r >= major_end_r;

  always_comb begin
    if (!error_r[ERR_W-1]) begin
      error_nxt = error_r + inc_diagonal_r;
      minor_nxt = flags_r.minor_down ? (minor_pos_r - 1'b1) : (minor_pos_r + 1'b1);
    end else begin
      error_nxt = error_r + {1'b0, inc_straight_r};
      minor_nxt = minor_pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r       <= 1'b0;
      flags_r        <= '0;
      major_pos_r    <= '0;
      major_end_r    <= '0;
      minor_pos_r    <= '0;
      error_r        <= '0;
      inc_straight_r <= '0;
      inc_diagonal_r <= '0;
      color_r        <= '0;
      col_valid_r    <= 1'b0;
      beat_r         <= '0;
    end else begin
      // a new column replaces the one whose last pixel leaves this cycle
      if (tick_go) begin
        col_valid_r <= 1'b1;
        beat_r      <= '0;
      end else if (last_beat_xfer) begin
        col_valid_r <= 1'b0;
      end else if (out_xfer) begin
        beat_r <= beat_r + 2'd1;
      end
      if (load_go) begin
        active_r       <= 1'b1;
        flags_r        <= su_flags;
        major_pos_r    <= su_major_pos;
        major_end_r    <= su_major_end;
        minor_pos_r    <= su_minor_pos;
        error_r        <= su_error_init;
        inc_straight_r <= su_inc_straight;
        inc_diagonal_r <= su_inc_diagonal;
        color_r        <= in_chan.pen_color;
      end else if (tick_go) begin
        // snapshot the column, then advance the walk
        error_r     <= error_nxt;
        minor_pos_r <= minor_nxt;
        if (last_col) begin
          active_r <= 1'b0;
        end else begin
          major_pos_r <= major_pos_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_go) begin
      col_swapped_r <= flags_r.axis_swapped;
      col_last_r    <= last_col;
      col_major_r   <= major_pos_r;
      col_minor_r   <= minor_pos_r;
      col_color_r   <= color_r;
    end
  end

  // minor-1, minor, minor+1 across the three beats; -1 wraps to all ones
  assign minor_out = {2'b00, col_minor_r} + {{N{1'b0}}, beat_r} - {{(N+1){1'b0}}, 1'b1};
  assign major_out = {2'b00, col_major_r};

  assign out_chan.valid       = col_valid_r;
  assign out_chan.pixel_x     = col_swapped_r ? minor_out : major_out;
  assign out_chan.pixel_y     = col_swapped_r ? major_out : minor_out;
  assign out_chan.pixel_color = col_color_r;
  assign out_chan.line_done   = col_last_r && (beat_r == LAST_BEAT);

  `TLR_ASSERT_IMP(a_done_on_last_beat, clk, rst_n,
                  out_chan.valid && out_chan.line_done, beat_r == LAST_BEAT)
  `TLR_ASSERT_NXT(a_tick_fills_column, clk, rst_n, tick_go, col_valid_r && beat_r == 2'd0)
  `TLR_ASSERT_NXT(a_beat_advances, clk, rst_n, out_xfer && beat_r != LAST_BEAT,
                  col_valid_r && beat_r == $past(beat_r) + 2'd1)
  `TLR_ASSERT_NXT(a_final_column_idles, clk, rst_n, tick_go && last_col, !active_r)

endmodule

`default_nettype wire
